[rtl/ffha_pkg.sv]
package ffha_pkg;

  // Heap geometry.
  localparam int unsigned HEAP_GRANULES = 4096;
  localparam int unsigned GRANULE_BYTES = 16;
  localparam int unsigned GRAN_SHIFT    = $clog2(GRANULE_BYTES);
  localparam int unsigned IDX_W         = $clog2(HEAP_GRANULES);
  // Chunk sizes and the heap limit hold values up to HEAP_GRANULES.
  localparam int unsigned SIZE_W        = IDX_W + 1;
  // Walk positions may step past the end of the store before they are checked.
  localparam int unsigned POS_W         = IDX_W + 2;
  localparam int unsigned HW_W          = 17;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned BYTES_W       = 16;

  // Configuration register indexes.
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;
  localparam logic [SIZE_W-1:0] LIMIT_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] LIMIT_MAX   = SIZE_W'(HEAP_GRANULES);
  localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(4096);

  // Request kinds.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_UNUSED  = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  // Chunk header as kept in the header store.
  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

endpackage

[rtl/ffha_ram.sv]
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator with a chunk header at the start of every chunk.
// Input channel (in_*): one request per item. in_tuser is the command
// (allocate or free); in_tdata carries the byte count and the address to free.
// Result channel (out_*): exactly one result item per request, with the data
// address, the status in out_tuser and the current high-water byte offset.
// Configuration port (cfg_*): heap base address and heap limit in granules,
// written only while no request is in flight; the user must keep to this, the block does not enforce it.
// Each request walks the header chain in a 4096-entry header memory with one
// registered read port. An allocate walks headers up to the first chunk that
// fits; a free walks headers up to the freed chunk, then runs a merge walk that
// reads the neighbors behind each free run and writes each free run back. The
// result is offered in the same cycle in which the next request can be
// accepted. in_tready is high only while no request is in flight.
// A finished result sits in an output register; the block accepts the next
// request while it waits, and stalls only when a second result is ready
// before the first one has been taken.
// Reset (rst_n low, synchronous) empties the heap to a single end marker at
// granule 0, clears the high-water mark and drops any pending result.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] request_bytes, [47:16] free_address
  input  logic [0:0]  in_tuser,   // [0] cmd
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] result_address, [48:32] high_water_bytes
  output logic [1:0]  out_tuser,  // [1:0] status
  // Configuration.
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_START,
    S_A_LIM,
    S_A_EVAL,
    S_A_TAKE,
    S_F_START,
    S_F_WALK,
    S_F_STEP,
    S_F_CHK,
    S_M_TOP,
    S_M_CUR,
    S_M_NX,
    S_M_NXD,
    S_M_WB,
    S_DONE
  } state_t;

  localparam int unsigned IDX_W  = ffha_pkg::IDX_W;
  localparam int unsigned SIZE_W = ffha_pkg::SIZE_W;
  localparam int unsigned POS_W  = ffha_pkg::POS_W;
  localparam int unsigned HW_W   = ffha_pkg::HW_W;
  localparam int unsigned ADDR_W = ffha_pkg::ADDR_W;
  localparam int unsigned GS     = ffha_pkg::GRAN_SHIFT;

  state_t                      state_r, state_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [SIZE_W-1:0]           need_r, need_nxt;
  logic [POS_W-1:0]            tail_r, tail_nxt;
  logic [SIZE_W-1:0]           cur_r, cur_nxt;
  logic [IDX_W-1:0]            target_r, target_nxt;
  logic [ffha_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [ADDR_W-1:0]           faddr_r, faddr_nxt;
  logic [HW_W-1:0]             hw_r, hw_nxt;
  logic [ADDR_W-1:0]           res_addr_r, res_addr_nxt;
  ffha_pkg::status_t           res_st_r, res_st_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]           out_addr_r, out_addr_nxt;
  ffha_pkg::status_t           out_st_r, out_st_nxt;
  logic [HW_W-1:0]             out_hw_r, out_hw_nxt;
  logic [ADDR_W-1:0]           base_r, base_nxt;
  logic [SIZE_W-1:0]           limit_r, limit_nxt;
  logic                        e0_r, e0_nxt;
  logic                        rd0_r;

  // Header memory ports.
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  ffha_pkg::hdr_t              ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [ffha_pkg::HDR_W-1:0]  ram_rdata;
  ffha_pkg::hdr_t              hdr;

  // The one shared position adder.
  logic [POS_W-1:0]            add_a, add_b, add_sum;

  logic [ADDR_W-1:0]           base_al;
  logic [ADDR_W-1:0]           free_off;
  logic [ADDR_W-GS-1:0]        free_tgt;
  logic [SIZE_W-1:0]           cfg_lim;
  logic [ffha_pkg::BYTES_W:0]  need_full;
  logic [HW_W-1:0]             take_off;
  logic                        in_acc;
  logic                        out_load;

  ffha_ram #(
    .WIDTH (ffha_pkg::HDR_W),
    .DEPTH (ffha_pkg::HEAP_GRANULES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Granule 0 reads as the end marker until it is first written.
  assign hdr = (rd0_r && !e0_r) ? '0 : ffha_pkg::hdr_t'(ram_rdata);

  assign add_sum  = add_a + add_b;
  assign base_al  = {base_r[ADDR_W-1:GS], GS'(0)};
  assign free_off = faddr_r - base_al;
  assign free_tgt = free_off[ADDR_W-1:GS] - (ADDR_W-GS)'(1);
  assign need_full = {1'b0, bytes_r} + (ffha_pkg::BYTES_W+1)'(2 * ffha_pkg::GRANULE_BYTES - 1);
  assign take_off = {SIZE_W'(pos_r[IDX_W-1:0]) + SIZE_W'(1), GS'(0)};

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_hw_r, out_addr_r};
  assign out_tuser  = out_st_r;

  // Clamp a new heap limit into the legal range.
  always_comb begin
    cfg_lim = cfg_wdata[SIZE_W-1:0];
    if (cfg_lim < ffha_pkg::LIMIT_MIN) begin
      cfg_lim = ffha_pkg::LIMIT_MIN;
    end else if (cfg_lim > ffha_pkg::LIMIT_MAX) begin
      cfg_lim = ffha_pkg::LIMIT_MAX;
    end
  end

  // Operand select for the shared adder.
  always_comb begin
    add_a = pos_r;
    add_b = POS_W'(hdr.size);
    unique case (state_r)
      S_A_LIM:        add_b = POS_W'(need_r);
      S_M_NX, S_M_WB: add_b = POS_W'(cur_r);
      S_M_NXD:        add_a = POS_W'(cur_r);
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    need_nxt     = need_r;
    tail_nxt     = tail_r;
    cur_nxt      = cur_r;
    target_nxt   = target_r;
    bytes_nxt    = bytes_r;
    faddr_nxt    = faddr_r;
    hw_nxt       = hw_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    base_nxt     = base_r;
    limit_nxt    = limit_r;
    e0_nxt       = e0_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r[IDX_W-1:0];
    ram_wdata    = '0;
    ram_raddr    = pos_r[IDX_W-1:0];

    // Configuration writes.
    if (cfg_we) begin
      unique case (cfg_index)
        ffha_pkg::CFG_HEAP_BASE:  base_nxt  = cfg_wdata;
        ffha_pkg::CFG_HEAP_LIMIT: limit_nxt = cfg_lim;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          bytes_nxt    = in_tdata[15:0];
          faddr_nxt    = in_tdata[47:16];
          res_addr_nxt = '0;
          pos_nxt      = '0;
          state_nxt    = (in_tuser[0] == ffha_pkg::CMD_FREE) ? S_F_START : S_A_START;
        end
      end

      // Allocate: size the request in granules, header included.
      S_A_START: begin
        if (bytes_r == '0) begin
          res_st_nxt = ffha_pkg::ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          need_nxt  = need_full[ffha_pkg::BYTES_W:GS];
          state_nxt = S_A_LIM;
        end
      end

      // Room check for the chunk plus an end marker behind it, then read.
      S_A_LIM: begin
        if (add_sum >= POS_W'(limit_r) || pos_r[POS_W-1:IDX_W] != '0) begin
          res_st_nxt = ffha_pkg::ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          tail_nxt  = add_sum;
          state_nxt = S_A_EVAL;
        end
      end

      S_A_EVAL: begin
        if (!hdr.used && (hdr.size >= need_r || hdr.size == '0)) begin
          if (tail_r[POS_W-1:IDX_W] != '0) begin
            res_st_nxt = ffha_pkg::ST_NOSPACE;
            state_nxt  = S_DONE;
          end else begin
            ram_waddr = tail_r[IDX_W-1:0];
            if (hdr.size == '0) begin
              // Taking the end marker: a new marker goes behind the chunk.
              ram_we = 1'b1;
            end else if (hdr.size > need_r) begin
              // Split off the leftover as a free chunk.
              ram_we         = 1'b1;
              ram_wdata.size = hdr.size - need_r;
            end else begin
              need_nxt = hdr.size;
            end
            state_nxt = S_A_TAKE;
          end
        end else if (hdr.size == '0) begin
          // Used chunk of size zero: the chain is broken.
          res_st_nxt = ffha_pkg::ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          pos_nxt   = add_sum;
          state_nxt = S_A_LIM;
        end
      end

      S_A_TAKE: begin
        ram_we         = 1'b1;
        ram_wdata.used = 1'b1;
        ram_wdata.size = need_r;
        if (take_off > hw_r) begin
          hw_nxt = take_off;
        end
        res_addr_nxt = base_al + ADDR_W'(take_off);
        res_st_nxt   = ffha_pkg::ST_OK;
        state_nxt    = S_DONE;
      end

      // Free: check the address and turn it into a header index.
      S_F_START: begin
        if (free_off[ADDR_W-1:GS] == '0 || free_off[GS-1:0] != '0 ||
            free_tgt >= (ADDR_W-GS)'(limit_r)) begin
          res_st_nxt = ffha_pkg::ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          target_nxt = free_tgt[IDX_W-1:0];
          state_nxt  = S_F_WALK;
        end
      end

      // Walk the chain up to the target header.
      S_F_WALK: begin
        if (pos_r < POS_W'(target_r)) begin
          state_nxt = S_F_STEP;
        end else if (pos_r == POS_W'(target_r)) begin
          state_nxt = S_F_CHK;
        end else begin
          res_st_nxt = ffha_pkg::ST_UNUSED;
          state_nxt  = S_DONE;
        end
      end

      S_F_STEP: begin
        pos_nxt = add_sum;
        if (hdr.size == '0 || add_sum[POS_W-1:IDX_W] != '0) begin
          res_st_nxt = ffha_pkg::ST_UNUSED;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_F_WALK;
        end
      end

      S_F_CHK: begin
        if (!hdr.used) begin
          res_st_nxt = ffha_pkg::ST_UNUSED;
          state_nxt  = S_DONE;
        end else begin
          ram_we         = 1'b1;
          ram_wdata.size = hdr.size;
          pos_nxt        = '0;
          state_nxt      = S_M_TOP;
        end
      end

      // Merge walk over the whole chain.
      S_M_TOP: begin
        if (pos_r < POS_W'(limit_r) && pos_r[POS_W-1:IDX_W] == '0) begin
          state_nxt = S_M_CUR;
        end else begin
          res_st_nxt = ffha_pkg::ST_OK;
          state_nxt  = S_DONE;
        end
      end

      S_M_CUR: begin
        if (hdr.size == '0) begin
          res_st_nxt = ffha_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else if (hdr.used) begin
          pos_nxt   = add_sum;
          state_nxt = S_M_TOP;
        end else begin
          cur_nxt   = hdr.size;
          state_nxt = S_M_NX;
        end
      end

      // Read the neighbor behind the free run.
      S_M_NX: begin
        ram_raddr = add_sum[IDX_W-1:0];
        state_nxt = (add_sum[POS_W-1:IDX_W] == '0) ? S_M_NXD : S_M_WB;
      end

      S_M_NXD: begin
        if (hdr.used) begin
          state_nxt = S_M_WB;
        end else if (hdr.size == '0) begin
          // The run reaches the end: it becomes the end marker.
          ram_we     = 1'b1;
          hw_nxt     = {1'b0, pos_r[IDX_W-1:0], GS'(0)};
          res_st_nxt = ffha_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else begin
          cur_nxt   = add_sum[SIZE_W-1:0];
          state_nxt = S_M_NX;
        end
      end

      S_M_WB: begin
        ram_we         = 1'b1;
        ram_wdata.size = cur_r;
        pos_nxt        = add_sum;
        state_nxt      = S_M_TOP;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (ram_we && ram_waddr == '0) begin
      e0_nxt = 1'b1;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    out_hw_nxt    = out_hw_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = res_addr_r;
      out_st_nxt    = res_st_r;
      out_hw_nxt    = hw_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      limit_r     <= ffha_pkg::LIMIT_RESET;
      e0_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      limit_r     <= limit_nxt;
      e0_r        <= e0_nxt;
    end
    pos_r      <= pos_nxt;
    need_r     <= need_nxt;
    tail_r     <= tail_nxt;
    cur_r      <= cur_nxt;
    target_r   <= target_nxt;
    bytes_r    <= bytes_nxt;
    faddr_r    <= faddr_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_hw_r   <= out_hw_nxt;
    rd0_r      <= (ram_raddr == '0);
  end

endmodule

[rtl/ffha_checker.sv]
module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Reset drops any pending result.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  // A request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // Only a successful allocate returns a nonzero address.
  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ffha_pkg::ST_OK |-> out_tdata[31:0] == 32'd0)
    else $error("address returned with failing status");

  // The high-water offset never passes the full heap size.
  a_hw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[48] |-> out_tdata[47:32] == 16'd0)
    else $error("high-water offset out of range");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

[sim/heap_alloc_checker.sv]
module heap_alloc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] request_bytes, [47:16] free_address
  input  logic [0:0]  in_tuser,   // [0] cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // [31:0] result_address, [48:32] high_water_bytes
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          outstanding,
  output int          fail_count
);

  typedef struct packed {
    logic [ffha_pkg::ADDR_W-1:0] addr;
    ffha_pkg::status_t           status;
    logic [ffha_pkg::HW_W-1:0]   high_water;
  } heap_result_t;

  // Private copy of the heap: chunk headers, high-water mark and registers.
  ffha_pkg::hdr_t heap_hdr [ffha_pkg::HEAP_GRANULES];
  int unsigned    hw_ofs;
  logic [31:0]    base_reg;
  int unsigned    limit_gran;
  heap_result_t   pending_results [$];

  function automatic logic [31:0] base_floor();
    return base_reg - (base_reg % ffha_pkg::GRANULE_BYTES);
  endfunction

  // Join runs of free chunks; a run that reaches the end marker becomes the marker.
  function automatic void merge_free_runs();
    int unsigned pos;
    int unsigned nx;
    pos = 0;
    while (pos < limit_gran && pos < ffha_pkg::HEAP_GRANULES) begin
      if (heap_hdr[pos].size == 0) break;
      if (!heap_hdr[pos].used) begin
        nx = pos + heap_hdr[pos].size;
        while (nx < ffha_pkg::HEAP_GRANULES) begin
          if (heap_hdr[nx].used) break;
          if (heap_hdr[nx].size == 0) begin
            heap_hdr[pos] = '0;
            hw_ofs = pos * ffha_pkg::GRANULE_BYTES;
            return;
          end
          heap_hdr[pos].size = heap_hdr[pos].size + heap_hdr[nx].size;
          nx = nx + heap_hdr[nx].size;
        end
      end
      pos = pos + heap_hdr[pos].size;
    end
  endfunction

  // First-fit allocation over the header chain.
  function automatic ffha_pkg::status_t alloc_chunk(input logic [15:0] req,
                                                    output logic [31:0] addr);
    int unsigned need;
    int unsigned pos;
    int unsigned tail;
    int unsigned ofs;
    int unsigned csize;
    addr = '0;
    pos = 0;
    if (req == 0) return ffha_pkg::ST_BAD;
    need = (32'(req) + 2 * ffha_pkg::GRANULE_BYTES - 1) / ffha_pkg::GRANULE_BYTES;
    while (1'b1) begin
      if (pos + need + 1 > limit_gran || pos >= ffha_pkg::HEAP_GRANULES)
        return ffha_pkg::ST_NOSPACE;
      csize = 32'(heap_hdr[pos].size);
      if (!heap_hdr[pos].used && (csize >= need || csize == 0)) begin
        tail = pos + need;
        if (tail >= ffha_pkg::HEAP_GRANULES) return ffha_pkg::ST_NOSPACE;
        if (csize == 0) begin
          heap_hdr[tail] = '0;
        end else if (csize > need) begin
          heap_hdr[tail].used = 1'b0;
          heap_hdr[tail].size = ffha_pkg::SIZE_W'(csize - need);
        end else begin
          need = csize;
        end
        heap_hdr[pos].used = 1'b1;
        heap_hdr[pos].size = ffha_pkg::SIZE_W'(need);
        ofs = (pos + 1) * ffha_pkg::GRANULE_BYTES;
        if (ofs > hw_ofs) hw_ofs = ofs;
        addr = base_floor() + ofs;
        return ffha_pkg::ST_OK;
      end
      if (csize == 0) return ffha_pkg::ST_NOSPACE;
      pos = pos + csize;
    end
    return ffha_pkg::ST_NOSPACE;
  endfunction

  // Release the chunk whose data starts at addr, then merge.
  function automatic ffha_pkg::status_t free_chunk(input logic [31:0] addr);
    logic [31:0] ofs;
    int unsigned target;
    int unsigned pos;
    ofs = addr - base_floor();
    if (ofs < ffha_pkg::GRANULE_BYTES || ofs % ffha_pkg::GRANULE_BYTES != 0)
      return ffha_pkg::ST_BAD;
    target = ofs / ffha_pkg::GRANULE_BYTES - 1;
    if (target >= limit_gran || target >= ffha_pkg::HEAP_GRANULES) return ffha_pkg::ST_BAD;
    pos = 0;
    while (pos < target) begin
      if (heap_hdr[pos].size == 0) return ffha_pkg::ST_UNUSED;
      pos = pos + heap_hdr[pos].size;
      if (pos >= ffha_pkg::HEAP_GRANULES) return ffha_pkg::ST_UNUSED;
    end
    if (pos != target || !heap_hdr[pos].used) return ffha_pkg::ST_UNUSED;
    heap_hdr[pos].used = 1'b0;
    merge_free_runs();
    return ffha_pkg::ST_OK;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial outstanding = 0;

  // Results are checked before the item of the same edge is predicted.
  always @(posedge clk) begin
    heap_result_t want;
    heap_result_t got;
    logic [31:0]  a;
    int unsigned  v;
    if (!rst_n) begin
      for (int i = 0; i < ffha_pkg::HEAP_GRANULES; i++) heap_hdr[i] = '0;
      hw_ofs = 0;
      base_reg = '0;
      limit_gran = 32'(ffha_pkg::LIMIT_RESET);
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.addr = out_tdata[31:0];
        got.status = ffha_pkg::status_t'(out_tuser);
        got.high_water = out_tdata[48:32];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, address", got.addr, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.addr != want.addr)
            report_mismatch("result_address", got.addr, want.addr);
          if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.high_water != want.high_water)
            report_mismatch("high_water_bytes", 32'(got.high_water), 32'(want.high_water));
        end
      end
      if (cfg_we) begin
        if (cfg_index == ffha_pkg::CFG_HEAP_BASE) begin
          base_reg = cfg_wdata;
        end else begin
          v = 32'(cfg_wdata[ffha_pkg::SIZE_W-1:0]);
          if (v < 32'(ffha_pkg::LIMIT_MIN)) v = 32'(ffha_pkg::LIMIT_MIN);
          if (v > 32'(ffha_pkg::LIMIT_MAX)) v = 32'(ffha_pkg::LIMIT_MAX);
          limit_gran = v;
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == ffha_pkg::CMD_ALLOC) begin
          want.status = alloc_chunk(in_tdata[15:0], a);
          want.addr = a;
        end else begin
          want.status = free_chunk(in_tdata[47:16]);
          want.addr = '0;
        end
        want.high_water = hw_ofs[ffha_pkg::HW_W-1:0];
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

[sim/first_fit_heap_allocator_test.sv]
module first_fit_heap_allocator_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [15:0] request_bytes, [47:16] free_address
  logic [0:0]  in_tuser = '0;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [55:0] out_tdata;       // [31:0] result_address, [48:32] high_water_bytes
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  int          outstanding;
  int          fail_count;
  logic        calm = 1'b0;
  logic [31:0] cur_base = '0;
  logic [31:0] live_addrs [$];
  logic        sent_kinds [$];
  logic        done_kind;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  first_fit_heap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  heap_alloc_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Collect the addresses handed out, so that later frees can return them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready && sent_kinds.size() != 0) begin
        done_kind = sent_kinds.pop_front();
        if (done_kind == ffha_pkg::CMD_ALLOC &&
            ffha_pkg::status_t'(out_tuser) == ffha_pkg::ST_OK)
          live_addrs.push_back(out_tdata[31:0]);
      end
      if (in_tvalid && in_tready) sent_kinds.push_back(in_tuser[0]);
    end
  end

  // The result side stalls at random unless the run is in a calm stretch.
  always @(negedge clk) begin
    out_tready = calm || ($urandom_range(99) >= 14);
  end

  // Offer one item and hold it until it is taken; called at a falling edge.
  task automatic send_req(input logic cmd, input logic [15:0] bytes, input logic [31:0] addr);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 14) gap++;
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {addr, bytes};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic alloc_req(input logic [15:0] bytes);
    send_req(ffha_pkg::CMD_ALLOC, bytes, $urandom());
  endtask

  task automatic free_req(input logic [31:0] addr);
    send_req(ffha_pkg::CMD_FREE, 16'($urandom_range(65535)), addr);
  endtask

  // Wait until every result is back and the block has settled.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    cfg_index = idx;
    cfg_wdata = value;
    cfg_we = 1'b1;
    if (idx == ffha_pkg::CFG_HEAP_BASE)
      cur_base = value - (value % ffha_pkg::GRANULE_BYTES);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Return every chunk handed out so far, in random order.
  task automatic drain_heap();
    int idx;
    wait_idle();
    while (live_addrs.size() != 0) begin
      idx = $urandom_range(live_addrs.size() - 1);
      free_req(live_addrs[idx]);
      live_addrs.delete(idx);
    end
    wait_idle();
  endtask

  // Mostly alloc and free of live chunks, with bad and stray requests mixed in.
  task automatic run_random(input int count);
    int          roll;
    int          idx;
    logic [31:0] a;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if ($urandom_range(199) == 0) wait_idle();
      if (live_addrs.size() > 24 || (roll < 45 && live_addrs.size() != 0)) begin
        idx = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[idx];
        live_addrs.delete(idx);
        free_req(a);
      end else if (roll < 55) begin
        if ($urandom_range(1) == 0) begin
          a = cur_base + ffha_pkg::GRANULE_BYTES * $urandom_range(400);
          if ($urandom_range(3) == 0) a = a + $urandom_range(1, ffha_pkg::GRANULE_BYTES - 1);
        end else begin
          a = $urandom();
        end
        free_req(a);
      end else if (roll < 58) begin
        alloc_req(16'd0);
      end else if (roll < 61) begin
        alloc_req(16'($urandom_range(4096, 65535)));
      end else begin
        alloc_req(16'($urandom_range(1, 160)));
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed requests on a fresh heap at base zero.
    alloc_req(16'd0);          // zero-byte request
    alloc_req(16'd1);          // smallest chunk, data at 16
    alloc_req(16'd16);         // data at 48
    alloc_req(16'd17);         // three granules, data at 80
    alloc_req(16'd100);        // data at 128
    alloc_req(16'hFFFF);       // does not fit
    free_req(32'd0);           // below the first data address
    free_req(32'd24);          // not granule aligned
    free_req(32'hFFFF_FFF0);   // far beyond capacity
    free_req(32'd65552);       // just beyond capacity
    free_req(32'd65536);       // last granule, not a chunk
    free_req(32'd32);          // inside a chunk
    free_req(32'd48);
    free_req(32'd48);          // double free
    free_req(32'd80);          // merges with the chunk freed before
    alloc_req(16'd20);         // first fit with a split
    alloc_req(16'd17);         // skips a hole that is too small
    alloc_req(16'd1);          // exact fit into that hole
    free_req(32'd128);
    free_req(32'd256);         // run reaches the end, high water drops
    alloc_req(16'd4000);
    wait_idle();

    calm = 1'b1;
    run_random(80);
    calm = 1'b0;
    drain_heap();

    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'h1234_5678);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd200);
    run_random(80);
    drain_heap();

    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd8191);
    run_random(70);
    drain_heap();

    // Smallest heap: nothing can ever be allocated.
    write_reg(ffha_pkg::CFG_HEAP_BASE, $urandom());
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd0);
    run_random(15);
    drain_heap();

    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'd0);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd64);
    run_random(50);
    drain_heap();

    // Lower the limit while chunks are still in use, then raise it again.
    write_reg(ffha_pkg::CFG_HEAP_BASE, $urandom());
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd4096);
    run_random(70);
    wait_idle();
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd40);
    run_random(40);
    wait_idle();
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd4096);
    drain_heap();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a run that hangs.
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
